/* hdl/apv_pkg.sv */
// apv_pkg: types and constants shared by the arrow outline blocks.
// No dependencies.
package apv_pkg;

	localparam int COORD_BITS = 16;
	localparam int WIDTH_BITS = 12;
	localparam int DIR_BITS   = 14;
	localparam int EXT_BITS   = COORD_BITS + 3;
	localparam int NUM_VERTS  = 7;
	localparam int IDX_BITS   = 3;
	localparam int MAG_BITS   = COORD_BITS;
	localparam int LSQ_BITS   = 2 * MAG_BITS + 1;
	localparam int SQ_BITS    = LSQ_BITS + 9;
	localparam int SQ_ITERS   = (LSQ_BITS + 8 + 1) / 2;
	localparam int SQ_STEPS   = 3;
	localparam int SQ_CYCLES  = SQ_ITERS / SQ_STEPS;
	localparam int LEN_BITS   = SQ_ITERS;
	localparam int DIV_BITS   = DIR_BITS + 1;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_CYCLES = DIV_BITS / DIV_STEPS;
	localparam int DEN_BITS   = LEN_BITS + 1;
	localparam int NUM_BITS   = MAG_BITS + DIR_BITS + 5 + 1;
	localparam int PROD_BITS  = COORD_BITS + WIDTH_BITS + 1;
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_BITS   = 1;

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_VERTS - 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EXT_BITS-1:0]   ext_t;
	typedef logic [WIDTH_BITS-1:0]        width_t;

	typedef struct packed {
		coord_t src_x;
		coord_t src_y;
		coord_t dst_x;
		coord_t dst_y;
		width_t line_width;
	} apv_in_t;

	typedef struct packed {
		coord_t              vertex_x;
		coord_t              vertex_y;
		logic [IDX_BITS-1:0] vertex_index;
		logic                last_vertex;
	} apv_out_t;

	typedef struct packed {
		ext_t tx;
		ext_t ty;
		ext_t ex;
		ext_t ey;
		ext_t bx;
		ext_t by;
		ext_t hx;
		ext_t hy;
		ext_t fx;
		ext_t fy;
	} apv_geom_t;

endpackage

/* hdl/apv_front.sv */
// apv_front: accepts arrows, finds the unit direction (iterative square root,
// then iterative division) and the outline offsets. Depends on apv_pkg.
module apv_front import apv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  apv_in_t   arrow,
	output logic      geom_push,
	input  logic      geom_full,
	output apv_geom_t geom
);

	function automatic ext_t rnd_shift(input logic signed [PROD_BITS-1:0] x, input int s);
		logic [PROD_BITS-1:0] m;
		logic [PROD_BITS-1:0] r;
		begin
			m = x[PROD_BITS-1] ? PROD_BITS'(-x) : PROD_BITS'(x);
			r = (m + (PROD_BITS'(1) << (s - 1))) >> s;
			rnd_shift = x[PROD_BITS-1] ? -EXT_BITS'(r) : EXT_BITS'(r);
		end
	endfunction

	// stage 1: input register
	apv_in_t a_s1;
	logic    v_s1;

	// stage 2: square root
	apv_in_t               a_s2;
	logic                  v_s2, shrt_s2, zero_s2, nx_s2, ny_s2;
	logic [MAG_BITS-1:0]   ax_s2, ay_s2;
	logic [SQ_BITS-1:0]    n_s2, res_s2, bit_s2;
	logic [2:0]            cnt_s2;

	// stage 3: division
	apv_in_t               a_s3;
	logic                  v_s3, shrt_s3, zero_s3, nx_s3, ny_s3;
	logic [DEN_BITS-1:0]   den_s3;
	logic [DEN_BITS-1:0]   remx_s3, remy_s3;
	logic [DIV_BITS-1:0]   dlx_s3, dly_s3, qx_s3, qy_s3;
	logic [2:0]            cnt_s3;

	// stage 4: offset products
	apv_in_t                     a_s4;
	logic                        v_s4, shrt_s4;
	logic signed [PROD_BITS-1:0] pvx_s4, pvy_s4;

	logic done_s2, done_s3, adv1, adv2, adv3, free2, free3, free4;

	assign done_s2   = (cnt_s2 == 3'(SQ_CYCLES));
	assign done_s3   = (cnt_s3 == 3'(DIV_CYCLES));
	assign geom_push = v_s4 && !geom_full;
	assign free4     = !v_s4 || geom_push;
	assign adv3      = v_s3 && done_s3 && free4;
	assign free3     = !v_s3 || adv3;
	assign adv2      = v_s2 && done_s2 && free3;
	assign free2     = !v_s2 || adv2;
	assign adv1      = v_s1 && free2;
	assign full      = v_s1 && !free2;

	// stage 1 -> 2 arithmetic
	logic signed [COORD_BITS:0] dx, dy;
	logic [MAG_BITS-1:0]        ax, ay;
	logic [LSQ_BITS-1:0]        lsq;
	logic [LSQ_BITS-1:0]        w4sq;

	always_comb begin
		dx   = (COORD_BITS+1)'(a_s1.dst_x) - (COORD_BITS+1)'(a_s1.src_x);
		dy   = (COORD_BITS+1)'(a_s1.dst_y) - (COORD_BITS+1)'(a_s1.src_y);
		ax   = dx[COORD_BITS] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
		ay   = dy[COORD_BITS] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
		lsq  = LSQ_BITS'(ax) * LSQ_BITS'(ax) + LSQ_BITS'(ay) * LSQ_BITS'(ay);
		w4sq = (LSQ_BITS'(a_s1.line_width) * LSQ_BITS'(a_s1.line_width)) << 2;
	end

	// square root, three result bits a cycle
	logic [SQ_BITS-1:0] n_nx, r_nx, b_nx;

	always_comb begin
		n_nx = n_s2;
		r_nx = res_s2;
		b_nx = bit_s2;
		for (int j = 0; j < SQ_STEPS; j++) begin
			if (n_nx >= r_nx + b_nx) begin
				n_nx = n_nx - (r_nx + b_nx);
				r_nx = (r_nx >> 1) + b_nx;
			end else begin
				r_nx = r_nx >> 1;
			end
			b_nx = b_nx >> 2;
		end
	end

	// stage 2 -> 3 division setup
	logic [LEN_BITS-1:0] len8;
	logic [NUM_BITS-1:0] numx, numy;

	always_comb begin
		len8 = res_s2[LEN_BITS-1:0];
		numx = (NUM_BITS'(ax_s2) << (DIR_BITS + 5)) + NUM_BITS'(len8);
		numy = (NUM_BITS'(ay_s2) << (DIR_BITS + 5)) + NUM_BITS'(len8);
	end

	// restoring division, three quotient bits a cycle
	logic [DEN_BITS-1:0] rx_nx, ry_nx;
	logic [DIV_BITS-1:0] dlx_nx, dly_nx, qx_nx, qy_nx;
	logic [DEN_BITS:0]   tx_w, ty_w;

	always_comb begin
		rx_nx  = remx_s3;
		ry_nx  = remy_s3;
		dlx_nx = dlx_s3;
		dly_nx = dly_s3;
		qx_nx  = qx_s3;
		qy_nx  = qy_s3;
		tx_w   = '0;
		ty_w   = '0;
		for (int j = 0; j < DIV_STEPS; j++) begin
			tx_w = {rx_nx, dlx_nx[DIV_BITS-1]};
			ty_w = {ry_nx, dly_nx[DIV_BITS-1]};
			dlx_nx = dlx_nx << 1;
			dly_nx = dly_nx << 1;
			if (tx_w >= (DEN_BITS+1)'(den_s3)) begin
				tx_w  = tx_w - (DEN_BITS+1)'(den_s3);
				qx_nx = {qx_nx[DIV_BITS-2:0], 1'b1};
			end else begin
				qx_nx = {qx_nx[DIV_BITS-2:0], 1'b0};
			end
			if (ty_w >= (DEN_BITS+1)'(den_s3)) begin
				ty_w  = ty_w - (DEN_BITS+1)'(den_s3);
				qy_nx = {qy_nx[DIV_BITS-2:0], 1'b1};
			end else begin
				qy_nx = {qy_nx[DIV_BITS-2:0], 1'b0};
			end
			rx_nx = tx_w[DEN_BITS-1:0];
			ry_nx = ty_w[DEN_BITS-1:0];
		end
	end

	// stage 3 -> 4 signed direction times width
	logic signed [COORD_BITS-1:0] vx, vy;
	logic signed [WIDTH_BITS:0]   ws;

	always_comb begin
		vx = zero_s3 ? '0 : (nx_s3 ? -COORD_BITS'(qx_s3) : COORD_BITS'(qx_s3));
		vy = zero_s3 ? '0 : (ny_s3 ? -COORD_BITS'(qy_s3) : COORD_BITS'(qy_s3));
		ws = {1'b0, a_s3.line_width};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			cnt_s2 <= '0;
			cnt_s3 <= '0;
		end else begin
			if (push && !full)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;

			if (adv1) begin
				v_s2   <= 1'b1;
				cnt_s2 <= '0;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end else if (v_s2 && !done_s2) begin
				cnt_s2 <= cnt_s2 + 3'd1;
			end

			if (adv2) begin
				v_s3   <= 1'b1;
				cnt_s3 <= '0;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end else if (v_s3 && !done_s3) begin
				cnt_s3 <= cnt_s3 + 3'd1;
			end

			if (adv3)
				v_s4 <= 1'b1;
			else if (geom_push)
				v_s4 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			a_s1 <= arrow;

		if (adv1) begin
			a_s2    <= a_s1;
			ax_s2   <= ax;
			ay_s2   <= ay;
			nx_s2   <= dx[COORD_BITS];
			ny_s2   <= dy[COORD_BITS];
			zero_s2 <= (lsq == '0);
			shrt_s2 <= (lsq <= w4sq);
			n_s2    <= SQ_BITS'(lsq) << 8;
			res_s2  <= '0;
			bit_s2  <= SQ_BITS'(1) << (2 * (SQ_ITERS - 1));
		end else if (v_s2 && !done_s2) begin
			n_s2   <= n_nx;
			res_s2 <= r_nx;
			bit_s2 <= b_nx;
		end

		if (adv2) begin
			a_s3    <= a_s2;
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			zero_s3 <= zero_s2;
			shrt_s3 <= shrt_s2;
			den_s3  <= {len8, 1'b0};
			remx_s3 <= DEN_BITS'(numx >> DIV_BITS);
			remy_s3 <= DEN_BITS'(numy >> DIV_BITS);
			dlx_s3  <= numx[DIV_BITS-1:0];
			dly_s3  <= numy[DIV_BITS-1:0];
			qx_s3   <= '0;
			qy_s3   <= '0;
		end else if (v_s3 && !done_s3) begin
			remx_s3 <= rx_nx;
			remy_s3 <= ry_nx;
			dlx_s3  <= dlx_nx;
			dly_s3  <= dly_nx;
			qx_s3   <= qx_nx;
			qy_s3   <= qy_nx;
		end

		if (adv3) begin
			a_s4    <= a_s3;
			shrt_s4 <= shrt_s3;
			pvx_s4  <= PROD_BITS'(vx) * PROD_BITS'(ws);
			pvy_s4  <= PROD_BITS'(vy) * PROD_BITS'(ws);
		end
	end

	// outline points
	ext_t ex, ey;

	always_comb begin
		ex      = EXT_BITS'(a_s4.dst_x) - rnd_shift(pvx_s4, DIR_BITS - 1);
		ey      = EXT_BITS'(a_s4.dst_y) - rnd_shift(pvy_s4, DIR_BITS - 1);
		geom.tx = EXT_BITS'(a_s4.dst_x);
		geom.ty = EXT_BITS'(a_s4.dst_y);
		geom.ex = ex;
		geom.ey = ey;
		geom.bx = shrt_s4 ? ex : EXT_BITS'(a_s4.src_x);
		geom.by = shrt_s4 ? ey : EXT_BITS'(a_s4.src_y);
		geom.hx = rnd_shift(pvy_s4, DIR_BITS + 1);
		geom.hy = -rnd_shift(pvx_s4, DIR_BITS + 1);
		geom.fx = rnd_shift(pvy_s4, DIR_BITS);
		geom.fy = -rnd_shift(pvx_s4, DIR_BITS);
	end

endmodule

/* hdl/apv_fifo.sv */
// apv_fifo: short queue of outline records between front and back.
// Depends on apv_pkg.
module apv_fifo import apv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  apv_geom_t wdata,
	output logic      full,
	input  logic      rd,
	output logic      empty,
	output apv_geom_t rdata
);

	apv_geom_t           mem [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wptr_q, rptr_q;
	logic [PTR_BITS:0]   cnt_q;

	assign full  = (cnt_q == (PTR_BITS+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem[wptr_q] <= wdata;
	end

endmodule

/* hdl/apv_back.sv */
// apv_back: walks the seven outline vertices of the queued record and
// saturates them into the output register. Depends on apv_pkg.
module apv_back import apv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      geom_empty,
	input  apv_geom_t geom,
	output logic      geom_pop,
	output logic      empty,
	input  logic      pop,
	output apv_out_t  vertex
);

	apv_out_t            out_q;
	logic                ov_q;
	logic [IDX_BITS-1:0] idx_q;
	logic                load;
	ext_t                base, off, sum;
	logic                neg;
	coord_t              sat;

	localparam ext_t HI = EXT_BITS'((1 << (COORD_BITS - 1)) - 1);
	localparam ext_t LO = -HI - EXT_BITS'(1);

	assign load     = !geom_empty && (!ov_q || pop);
	assign geom_pop = load && (idx_q == LAST_IDX);
	assign empty    = !ov_q;
	assign vertex   = out_q;

	always_comb begin
		base = geom.ex;
		off  = geom.hx;
		neg  = 1'b0;
		case (idx_q)
			3'd0: begin base = geom.bx; off = geom.hx; neg = 1'b0; end
			3'd1: begin base = geom.bx; off = geom.hx; neg = 1'b1; end
			3'd2: begin base = geom.ex; off = geom.hx; neg = 1'b1; end
			3'd3: begin base = geom.ex; off = geom.fx; neg = 1'b1; end
			3'd4: begin base = geom.tx; off = '0;      neg = 1'b0; end
			3'd5: begin base = geom.ex; off = geom.fx; neg = 1'b0; end
			default: begin base = geom.ex; off = geom.hx; neg = 1'b0; end
		endcase
		sum = neg ? base - off : base + off;
		if (idx_q != 3'd0 && idx_q != 3'd1 && idx_q != 3'd4) begin
			// y component follows the same selection below
		end
		if (sum > HI)
			sat = coord_t'(HI);
		else if (sum < LO)
			sat = coord_t'(LO);
		else
			sat = coord_t'(sum);
	end

	ext_t basey, offy, sumy;
	coord_t saty;

	always_comb begin
		basey = geom.ey;
		offy  = geom.hy;
		unique case (idx_q)
			3'd0, 3'd1: begin basey = geom.by; offy = geom.hy; end
			3'd2, 3'd6: begin basey = geom.ey; offy = geom.hy; end
			3'd3, 3'd5: begin basey = geom.ey; offy = geom.fy; end
			3'd4:       begin basey = geom.ty; offy = '0;      end
			default:    begin basey = geom.ey; offy = geom.hy; end
		endcase
		sumy = neg ? basey - offy : basey + offy;
		if (sumy > HI)
			saty = coord_t'(HI);
		else if (sumy < LO)
			saty = coord_t'(LO);
		else
			saty = coord_t'(sumy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.vertex_x     <= sat;
			out_q.vertex_y     <= saty;
			out_q.vertex_index <= idx_q;
			out_q.last_vertex  <= (idx_q == LAST_IDX);
		end
	end

endmodule

/* hdl/arrow_polygon_vertices_core.sv */
// arrow_polygon_vertices_core: top level of the arrow outline generator.
// Depends on apv_pkg, apv_front, apv_fifo, apv_back.
//
// Input queue: drive arrow and push; a beat is taken at a clock edge with
// push high and full low. Each arrow gives seven vertex beats, in outline
// order, on the output queue: vertex is valid while empty is low and is
// taken at an edge with pop high.
// The arrow rate is set by the square root unit (3 result bits a cycle
// over 21 bits); the division unit (3 quotient bits a cycle) runs beside
// it on the previous arrow. The output side gives one vertex a cycle while
// pop is high and the queue is not empty, 7 per arrow.
// A two-entry queue parts the direction front end from the vertex walker,
// so either side may stall alone. While pop stays low the current vertex
// holds and the front keeps taking arrows until its stages and the queue
// fill, then full rises.
// Reset empties every stage and the queue; no clearing pass is needed.
module arrow_polygon_vertices_core import apv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  apv_in_t  arrow,
	output logic     empty,
	input  logic     pop,
	output apv_out_t vertex
);

	apv_geom_t g_wr, g_rd;
	logic      g_push, g_full, g_pop, g_empty;

	apv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.arrow     (arrow),
		.geom_push (g_push),
		.geom_full (g_full),
		.geom      (g_wr)
	);

	apv_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (g_push),
		.wdata  (g_wr),
		.full   (g_full),
		.rd     (g_pop),
		.empty  (g_empty),
		.rdata  (g_rd)
	);

	apv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom_empty (g_empty),
		.geom       (g_rd),
		.geom_pop   (g_pop),
		.empty      (empty),
		.pop        (pop),
		.vertex     (vertex)
	);

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (vertex.last_vertex == (vertex.vertex_index == LAST_IDX)))
		else $error("last flag out of step with vertex index");

	a_index_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && vertex.vertex_index != LAST_IDX) |=>
		(!empty && vertex.vertex_index == $past(vertex.vertex_index) + 3'd1))
		else $error("vertex walk broke inside an arrow");

endmodule

/* tb/arrow_polygon_vertices_core_tb.sv */
// Testbench for arrow_polygon_vertices_core: drives arrows and checks each vertex
// against an in-bench fixed-point outline calculator. Depends on apv_pkg and the core RTL.
`timescale 1ns / 100ps

module arrow_polygon_vertices_core_tb;
	import apv_pkg::*;

	localparam int STALL_LIMIT = 3000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     full;
	apv_in_t  arrow = '0;
	logic     empty;
	logic     pop = 1'b0;
	apv_out_t vertex;

	apv_out_t vertex_q[$];
	int       fails = 0;
	int       arrows_sent = 0;
	int       verts_seen = 0;
	int       quiet_cycles = 0;
	bit       gaps_on = 1'b1;
	int       pop_hold = 0;

	arrow_polygon_vertices_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .arrow(arrow),
		.empty(empty), .pop(pop), .vertex(vertex)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_off(longint x, int s);
		longint m;
		m = (x < 0) ? -x : x;
		m = (m + (longint'(1) <<< (s - 1))) >>> s;
		return (x < 0) ? -m : m;
	endfunction

	function automatic coord_t clamp_coord(longint x);
		if (x > 32767) return coord_t'(32767);
		if (x < -32768) return coord_t'(-32768);
		return coord_t'(x);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_comp(longint d, longint unsigned len8);
		longint unsigned num, q;
		num = longint'((d < 0) ? -d : d) << (DIR_BITS + 5);
		q = (num + len8) / (2 * len8);
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void predict_outline(apv_in_t a);
		longint sx, sy, tx, ty, w, dx, dy, vx, vy, ex, ey, bx, by, px, py, hx, hy, fx, fy;
		longint unsigned lsq, len8;
		bit shrt;
		longint xs[7], ys[7];
		apv_out_t o;
		sx = a.src_x; sy = a.src_y; tx = a.dst_x; ty = a.dst_y;
		w = a.line_width;
		dx = tx - sx; dy = ty - sy;
		lsq = dx * dx + dy * dy;
		shrt = lsq <= 4 * w * w;
		vx = 0; vy = 0;
		if (lsq != 0) begin
			len8 = floor_sqrt(lsq << 8);
			vx = unit_comp(dx, len8);
			vy = unit_comp(dy, len8);
		end
		ex = tx - round_off(vx * w, DIR_BITS - 1);
		ey = ty - round_off(vy * w, DIR_BITS - 1);
		bx = shrt ? ex : sx;
		by = shrt ? ey : sy;
		px = vy; py = -vx;
		hx = round_off(px * w, DIR_BITS + 1);
		hy = round_off(py * w, DIR_BITS + 1);
		fx = round_off(px * w, DIR_BITS);
		fy = round_off(py * w, DIR_BITS);
		xs = '{bx + hx, bx - hx, ex - hx, ex - fx, tx, ex + fx, ex + hx};
		ys = '{by + hy, by - hy, ey - hy, ey - fy, ty, ey + fy, ey + hy};
		for (int k = 0; k < NUM_VERTS; k++) begin
			o.vertex_x = clamp_coord(xs[k]);
			o.vertex_y = clamp_coord(ys[k]);
			o.vertex_index = IDX_BITS'(k);
			o.last_vertex = (o.vertex_index == LAST_IDX);
			vertex_q.push_back(o);
		end
	endfunction

	task automatic send_arrow(input coord_t sx, sy, tx, ty, input width_t w);
		apv_in_t a;
		a = '{src_x: sx, src_y: sy, dst_x: tx, dst_y: ty, line_width: w};
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		arrow <= a;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_outline(a);
		arrows_sent++;
	endtask

	// random beat: mostly arrows of bounded length (deltas within 600 or 8000), some full-range noise
	task automatic send_random_arrow();
		coord_t sx, sy;
		int dx, dy;
		width_t w;
		sx = coord_t'($urandom);
		sy = coord_t'($urandom);
		w = width_t'($urandom);
		case ($urandom_range(0, 3))
			0: send_arrow(sx, sy, coord_t'($urandom), coord_t'($urandom), w);
			1: begin
				w = width_t'($urandom_range(0, 200));
				dx = $urandom_range(0, 1200) - 600;
				dy = $urandom_range(0, 1200) - 600;
				send_arrow(sx, sy, coord_t'(sx + dx), coord_t'(sy + dy), w);
			end
			default: begin
				dx = $urandom_range(0, 16000) - 8000;
				dy = $urandom_range(0, 16000) - 8000;
				send_arrow(sx, sy, coord_t'(sx + dx), coord_t'(sy + dy), w);
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (!arst_n || !gaps_on) begin
			pop <= arst_n;
		end else if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			pop_hold <= $urandom_range(0, 12);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		apv_out_t e;
		if (arst_n && pop && !empty) begin
			verts_seen++;
			if (vertex_q.size() == 0) begin
				$display("%0t: vertex with none expected: got %p", $time, vertex);
				fails++;
			end else begin
				e = vertex_q.pop_front();
				if (vertex.vertex_x !== e.vertex_x || vertex.vertex_y !== e.vertex_y ||
				    vertex.vertex_index !== e.vertex_index ||
				    vertex.last_vertex !== e.last_vertex) begin
					$display("%0t: vertex mismatch: expected %p, actual %p", $time, e, vertex);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired, %0d vertices outstanding", $time, vertex_q.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_extremes();
		send_arrow(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 12'd4095);
		send_arrow(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 12'd4095);
		send_arrow(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 12'd0);
		send_arrow(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 12'd2048);
		send_arrow(16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 12'd1);
		send_arrow(16'sd32000, 16'sd0, 16'sd32767, 16'sd0, 12'd4095);
	endtask

	task automatic test_degenerate();
		send_arrow(16'sd100, 16'sd100, 16'sd100, 16'sd100, 12'd50);
		send_arrow(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 12'd4095);
		send_arrow(16'sd5, -16'sd7, 16'sd5, -16'sd7, 12'd0);
		send_arrow(16'sd0, 16'sd0, 16'sd3000, -16'sd4000, 12'd0);
	endtask

	task automatic test_short_arrows();
		send_arrow(16'sd0, 16'sd0, 16'sd200, 16'sd0, 12'd100);
		send_arrow(16'sd0, 16'sd0, 16'sd201, 16'sd0, 12'd100);
		send_arrow(16'sd0, 16'sd0, -16'sd199, 16'sd0, 12'd100);
		send_arrow(16'sd10, 16'sd10, 16'sd40, 16'sd50, 12'd25);
		send_arrow(16'sd10, 16'sd10, 16'sd40, 16'sd50, 12'd24);
		send_arrow(-16'sd300, 16'sd500, -16'sd310, 16'sd480, 12'd4095);
		send_arrow(16'sd1, 16'sd1, 16'sd2, 16'sd2, 12'd1);
	endtask

	task automatic test_directions();
		send_arrow(16'sd0, 16'sd0, 16'sd0, 16'sd1000, 12'd64);
		send_arrow(16'sd0, 16'sd0, -16'sd1000, 16'sd0, 12'd64);
		send_arrow(16'sd0, 16'sd0, 16'sd777, -16'sd777, 12'd333);
		send_arrow(16'sd500, -16'sd200, -16'sd1234, -16'sd5678, 12'd999);
	endtask

	task automatic test_random(input int n);
		repeat (n) send_random_arrow();
	endtask

	task automatic test_back_to_back(input int n);
		gaps_on = 1'b0;
		repeat (n) send_random_arrow();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_degenerate();
		test_short_arrows();
		test_directions();
		test_random(100);
		test_back_to_back(30);
		push <= 1'b0;
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d arrows and %0d vertices: extremes, zero length, short heads,",
			arrows_sent, verts_seen);
		$display("zero and full width, random arrows with random stalls on both sides.");
		if (fails == 0 && vertex_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d vertices missing", fails, vertex_q.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/apv_pkg.sv
hdl/apv_front.sv
hdl/apv_fifo.sv
hdl/apv_back.sv
hdl/arrow_polygon_vertices_core.sv
tb/arrow_polygon_vertices_core_tb.sv
